>>> rtl/assert_macros.svh
// Assertion macros used by the checker file hst_checker.sv.
// Expects signals named clk and rst in the scope where the macros are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define HST_CHECK(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("hst check failed");

// Checked at every edge, reset included.
`define HST_CHECK_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) (prop)) \
    else $error("hst check failed");

`endif

>>> rtl/hst_pkg.sv
// Shared types, codes and arithmetic helpers for the history score table.
// No dependencies.
`default_nettype none

package hst_pkg;

  localparam int DATA_W  = 32;
  localparam int IDX_W   = 10;
  localparam int DEPTH_W = 8;
  localparam int LIMIT_W = 31;
  localparam int BONUS_W = 2 * DEPTH_W;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100000000);

  typedef enum logic [1:0] {
    KIND_UPDATE = 2'd0,
    KIND_AGE    = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SW_SUB  = 2'd0,
    SW_HALF = 2'd1,
    SW_AGE  = 2'd2,
    SW_ZERO = 2'd3
  } sweep_op_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] entry_value;
    logic                     halved;
  } result_t;

  function automatic logic signed [DATA_W-1:0] sat32(logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

  // Divide by two, truncating toward zero.
  function automatic logic signed [DATA_W-1:0] half_tz(logic signed [DATA_W-1:0] x);
    logic signed [DATA_W-1:0] t;
    t = x + $signed(DATA_W'(x[DATA_W-1]));
    return t >>> 1;
  endfunction

  // Divide by eight, truncating toward zero.
  function automatic logic signed [DATA_W-1:0] div8_tz(logic signed [DATA_W-1:0] x);
    logic signed [DATA_W-1:0] t;
    t = x + (x[DATA_W-1] ? $signed(DATA_W'(7)) : $signed(DATA_W'(0)));
    return t >>> 3;
  endfunction

  function automatic logic signed [DATA_W-1:0] sweep_fn(sweep_op_t op,
                                                       logic signed [DATA_W-1:0] x,
                                                       logic [BONUS_W-1:0] b);
    logic signed [DATA_W:0]   d;
    logic signed [DATA_W-1:0] r;
    d = {x[DATA_W-1], x} - $signed({{(DATA_W+1-BONUS_W){1'b0}}, b});
    case (op)
      SW_SUB:  r = sat32(d);
      SW_HALF: r = half_tz(x);
      SW_AGE:  r = div8_tz(x);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hst_ifs.sv
// Channel interfaces: input items, result items and the limit register write.
// Depends on hst_pkg.
`default_nettype none

interface hst_item_if import hst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [IDX_W-1:0]   entry_index;
  logic [DEPTH_W-1:0] update_depth;
  modport source (output valid, kind, entry_index, update_depth, input ready);
  modport sink   (input valid, kind, entry_index, update_depth, output ready);
endinterface

interface hst_result_if import hst_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] entry_value;
  logic                     halved;
  modport source (output valid, entry_value, halved, input ready);
  modport sink   (input valid, entry_value, halved, output ready);
endinterface

interface hst_cfg_if import hst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] score_limit;
  modport source (output valid, score_limit, input ready);
  modport sink   (input valid, score_limit, output ready);
endinterface

`default_nettype wire

>>> rtl/hst_ram.sv
// Score table storage: one write port, one read port, registered read data.
// Depends on hst_pkg.
`default_nettype none

module hst_ram import hst_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire  [AW-1:0]           waddr,
  input  wire  signed [DATA_W-1:0] wdata,
  input  wire  [AW-1:0]           raddr,
  output logic signed [DATA_W-1:0] rdata
);

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/hst_ctrl.sv
// Sequencer: named-entry read-modify, whole-table sweeps and the result.
// Depends on hst_pkg and hst_ifs; drives the hst_ram ports.
`default_nettype none

module hst_ctrl import hst_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire                      clk,
  input  wire                      rst,
  hst_item_if.sink                 item,
  input  wire  [LIMIT_W-1:0]       score_limit,
  output logic                     done_valid,
  input  wire                      done_ready,
  output result_t                  done_res,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_waddr,
  output logic signed [DATA_W-1:0] ram_wdata,
  output logic [AW-1:0]            ram_raddr,
  input  wire  signed [DATA_W-1:0] ram_rdata
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] LAST = CW'(DEPTH);

  typedef enum logic [6:0] {
    ST_INIT  = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_RD    = 7'b0000100,
    ST_LOAD  = 7'b0001000,
    ST_NAMED = 7'b0010000,
    ST_SWEEP = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  state_t                   state;
  kind_t                    op;
  sweep_op_t                sw_op;
  logic [AW-1:0]            idx;
  logic [BONUS_W-1:0]       bonus;
  logic signed [DATA_W-1:0] s1;
  logic signed [DATA_W-1:0] named;
  logic                     over;
  result_t                  res;
  logic [CW-1:0]            cnt;
  logic                     rd_pend;
  logic [AW-1:0]            wr_addr;

  logic                     sweep_on;
  logic                     sweep_end;
  logic                     idx_ok;
  logic signed [DATA_W-1:0] named_next;
  logic                     over_next;

  assign item.ready = (state == ST_IDLE);
  assign sweep_on   = (state == ST_SWEEP) || (state == ST_INIT);
  assign sweep_end  = (cnt == LAST) && !rd_pend;
  assign idx_ok     = 32'(item.entry_index) < DEPTH;

  assign named_next = sat32({s1[DATA_W-1], s1} - $signed({1'b0, {(DATA_W-BONUS_W){1'b0}}, bonus}));
  assign over_next  = named_next > $signed({1'b0, score_limit});

  assign done_valid = (state == ST_DONE);
  assign done_res   = res;

  // Reads run one entry ahead of the write-back, so the two never hit the same entry.
  always_comb begin
    ram_raddr = sweep_on ? cnt[AW-1:0] : idx;
    ram_we    = sweep_on && rd_pend;
    ram_waddr = wr_addr;
    if (sw_op == SW_SUB && wr_addr == idx) begin
      ram_wdata = named;
    end else begin
      ram_wdata = sweep_fn(sw_op, ram_rdata, bonus);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      sw_op   <= SW_ZERO;
      cnt     <= '0;
      rd_pend <= 1'b0;
      over    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (item.valid) begin
            op      <= kind_t'(item.kind);
            idx     <= AW'(item.entry_index);
            bonus   <= BONUS_W'(item.update_depth) * BONUS_W'(item.update_depth);
            res     <= '0;
            cnt     <= '0;
            rd_pend <= 1'b0;
            case (kind_t'(item.kind))
              KIND_UPDATE, KIND_READ: begin
                state <= idx_ok ? ST_RD : ST_DONE;
              end
              KIND_AGE: begin
                sw_op <= SW_AGE;
                state <= ST_SWEEP;
              end
              default: begin
                sw_op <= SW_ZERO;
                state <= ST_SWEEP;
              end
            endcase
          end
        end
        ST_RD: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (op == KIND_READ) begin
            res.entry_value <= ram_rdata;
            state           <= ST_DONE;
          end else begin
            s1    <= sat32({ram_rdata[DATA_W-1], ram_rdata}
                           + $signed({{(DATA_W-BONUS_W){1'b0}}, bonus, 1'b0}));
            state <= ST_NAMED;
          end
        end
        ST_NAMED: begin
          named           <= named_next;
          over            <= over_next;
          res.entry_value <= over_next ? half_tz(named_next) : named_next;
          res.halved      <= over_next;
          sw_op           <= SW_SUB;
          state           <= ST_SWEEP;
        end
        ST_INIT, ST_SWEEP: begin
          rd_pend <= (cnt != LAST);
          wr_addr <= cnt[AW-1:0];
          if (cnt != LAST) begin
            cnt <= cnt + 1'b1;
          end
          if (sweep_end) begin
            if (state == ST_INIT) begin
              state <= ST_IDLE;
            end else if (sw_op == SW_SUB && over) begin
              sw_op <= SW_HALF;
              cnt   <= '0;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (done_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/history_score_table_top.sv
// History score table: PIECE_CODES x SQUARES signed 32-bit move-ordering scores
// in one single-port-write, single-port-read memory. After reset the block runs
// a clearing pass over all PIECE_CODES*SQUARES entries with item.ready low; the
// limit register can be written meanwhile. Every operation is bounded by the
// memory port handling one entry per cycle. A read fetches the named entry; an
// age or clear makes one pass over the table; an update reads and modifies the
// named entry, then makes a subtracting pass over the table and, if the named
// entry ends above the limit, a second, halving pass. One item is in work at a
// time; the next is taken while a result waits in the output register. Depends
// on hst_pkg, hst_ifs, hst_ram and hst_ctrl.
`default_nettype none

module history_score_table_top import hst_pkg::*; #(
  parameter int PIECE_CODES = 16,
  parameter int SQUARES     = 64
) (
  input  wire         clk,
  input  wire         rst,
  hst_item_if.sink    item,
  hst_result_if.source result,
  hst_cfg_if.sink     cfg
);

  localparam int DEPTH = PIECE_CODES * SQUARES;
  localparam int AW    = $clog2(DEPTH);

  logic [LIMIT_W-1:0]       score_limit;
  logic                     done_valid;
  logic                     done_ready;
  result_t                  done_res;
  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic signed [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic signed [DATA_W-1:0] ram_rdata;
  logic                     out_valid;
  result_t                  out_res;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_limit <= LIMIT_RESET;
    end else if (cfg.valid) begin
      score_limit <= cfg.score_limit;
    end
  end

  hst_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .score_limit(score_limit),
    .done_valid (done_valid),
    .done_ready (done_ready),
    .done_res   (done_res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  hst_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Output register decouples the result transfer from the sequencer.
  assign done_ready = !out_valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done_ready) begin
      out_valid <= done_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (done_valid && done_ready) begin
      out_res <= done_res;
    end
  end

  assign result.valid       = out_valid;
  assign result.entry_value = out_res.entry_value;
  assign result.halved      = out_res.halved;

endmodule

`default_nettype wire

>>> rtl/hst_checker.sv
// Port-level checks for the history score table, bound to the top level.
// Depends on assert_macros.svh and history_score_table_top.
`default_nettype none
`include "assert_macros.svh"

module hst_checker (
  input wire        clk,
  input wire        rst,
  input wire        item_valid,
  input wire        item_ready,
  input wire        result_valid,
  input wire        result_ready,
  input wire [31:0] entry_value,
  input wire        halved
);

  // Clearing pass holds the input off and no result is left over.
  `HST_CHECK_ALWAYS(a_reset_quiet, rst |=> !item_ready && !result_valid)
  // Once an item is taken, the input drops ready while the operation is in work.
  `HST_CHECK(a_busy_after_take, item_valid && item_ready |=> !item_ready)
  // A halving update only happens above a non-negative limit.
  `HST_CHECK(a_halved_nonneg, result_valid && halved |-> !entry_value[31])
  `HST_CHECK(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(entry_value) && $stable(halved))

endmodule

bind history_score_table_top hst_checker u_hst_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (item.valid),
  .item_ready  (item.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .entry_value (result.entry_value),
  .halved      (result.halved)
);

`default_nettype wire

>>> tb/tb_history_score_table_top.sv
// Self-checking testbench for history_score_table_top: drives score-table operations and
// limit writes, and checks every result against an in-bench mirror of the table.
// Depends on hst_pkg, hst_ifs and the RTL of history_score_table_top.

module tb_history_score_table_top;
  import hst_pkg::*;

  localparam int PIECE_CODES = 16;
  localparam int SQUARES     = 64;
  localparam int TABLE_SIZE  = PIECE_CODES * SQUARES;
  localparam int unsigned CYCLE_LIMIT = 6000000;
  localparam int LONG_HOLD   = 6000;
  localparam int SETTLE      = 4200;  // idle wait after the last result, before the verdict
  localparam logic [LIMIT_W-1:0] LIMIT_MAX = {LIMIT_W{1'b1}};

  // Mirror of the score table; keeps the results still owed by the block.
  class history_mirror;
    int                 scores [TABLE_SIZE];
    logic [LIMIT_W-1:0] score_limit;
    result_t            owed_results [$];
    int                 errors;

    function new();
      foreach (scores[i]) scores[i] = 0;
      score_limit = LIMIT_RESET;
      errors = 0;
    endfunction

    function int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    function void apply_item(kind_t k, logic [IDX_W-1:0] idx, logic [DEPTH_W-1:0] depth);
      result_t r;
      longint  bonus;
      r = '0;
      case (k)
        KIND_UPDATE: begin
          if (idx < TABLE_SIZE) begin
            bonus = longint'(depth) * longint'(depth);
            scores[idx] = clamp32(longint'(scores[idx]) + 2 * bonus);
            foreach (scores[i]) scores[i] = clamp32(longint'(scores[i]) - bonus);
            if (longint'(scores[idx]) > longint'(score_limit)) begin
              foreach (scores[i]) scores[i] = scores[i] / 2;  // truncates toward zero
              r.halved = 1'b1;
            end
            r.entry_value = scores[idx];
          end
        end
        KIND_AGE:   foreach (scores[i]) scores[i] = scores[i] / 8;
        KIND_CLEAR: foreach (scores[i]) scores[i] = 0;
        default: begin
          if (idx < TABLE_SIZE) r.entry_value = scores[idx];
        end
      endcase
      owed_results.push_back(r);
    endfunction

    function void match_result(logic signed [DATA_W-1:0] value, logic halved);
      result_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result transfer: entry_value %0d halved %0b", value, halved);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (value !== want.entry_value) begin
        $error("entry_value mismatch: expected %0d, actual %0d", want.entry_value, value);
        errors++;
      end
      if (halved !== want.halved) begin
        $error("halved mismatch: expected %0b, actual %0b", want.halved, halved);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int unsigned cycle_count = 0;
  bit hold_requested = 1'b0;
  int burst_left = 0;
  logic [IDX_W-1:0] hot_idx [8] = '{10'd0, 10'd1, 10'd63, 10'd64,
                                    10'd511, 10'd512, 10'd1022, 10'd1023};
  history_mirror mirror = new();

  hst_item_if   item_ch ();
  hst_result_if result_ch ();
  hst_cfg_if    cfg_ch ();

  history_score_table_top #(
    .PIECE_CODES(PIECE_CODES),
    .SQUARES    (SQUARES)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    if (rst === 1'b0 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      mirror.match_result(result_ch.entry_value, result_ch.halved);
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: random stall pattern in runs, plus one long hold on request.
  initial begin : result_stall
    int mode;
    int run;
    run = 0;
    mode = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requested) begin
        hold_requested = 1'b0;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      if (run == 0) begin
        mode = $urandom_range(0, 2);
        run = $urandom_range(1, 60);
      end
      run--;
      case (mode)
        0:       result_ch.ready <= 1'b1;
        1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
        default: result_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  task automatic offer_item(kind_t k, logic [IDX_W-1:0] idx, logic [DEPTH_W-1:0] depth);
    item_ch.valid        <= 1'b1;
    item_ch.kind         <= k;
    item_ch.entry_index  <= idx;
    item_ch.update_depth <= depth;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    mirror.apply_item(k, idx, depth);
  endtask

  task automatic pause_sender(int cycles);
    item_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // The do-while always waits for a clock edge, so valid is never lowered and raised in one step.
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    do @(posedge clk); while (mirror.owed_results.size() != 0);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.score_limit <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    mirror.score_limit = value;
  endtask

  task automatic run_phase(logic [LIMIT_W-1:0] limit, int count, bit long_hold);
    kind_t            k;
    logic [IDX_W-1:0]   idx;
    logic [DEPTH_W-1:0] depth;
    int               roll;
    wait_drained();
    write_limit(limit);
    if (long_hold) hold_requested = 1'b1;
    for (int n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        if ($urandom_range(0, 19) == 0) pause_sender($urandom_range(100, 2500));
        else pause_sender($urandom_range(1, 25));
        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                 : $urandom_range(1, 8);
      end
      burst_left--;
      roll = $urandom_range(0, 99);
      if (roll < 40)      k = KIND_UPDATE;
      else if (roll < 48) k = KIND_AGE;
      else if (roll < 54) k = KIND_CLEAR;
      else                k = KIND_READ;
      // half the traffic on a few hot entries so scores build up and go negative
      idx = $urandom_range(0, 1) ? hot_idx[$urandom_range(0, 7)]
                                 : IDX_W'($urandom_range(0, TABLE_SIZE - 1));
      roll = $urandom_range(0, 9);
      if (roll == 0)      depth = '0;
      else if (roll == 1) depth = '1;
      else                depth = DEPTH_W'($urandom_range(0, 255));
      offer_item(k, idx, depth);
    end
  endtask

  initial begin : stimulus
    rst                  <= 1'b1;
    item_ch.valid        <= 1'b0;
    item_ch.kind         <= KIND_READ;
    item_ch.entry_index  <= '0;
    item_ch.update_depth <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.score_limit   <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: cleared table, zero bonus, halving with negative entries, age, clear.
    // An index past the table cannot be formed at the default size.
    write_limit(LIMIT_W'(20000));
    offer_item(KIND_READ,   10'd0,    8'd0);
    offer_item(KIND_READ,   10'd1023, 8'd255);
    offer_item(KIND_UPDATE, 10'd1023, 8'd0);
    offer_item(KIND_UPDATE, 10'd0,    8'd3);
    offer_item(KIND_UPDATE, 10'd1023, 8'd255);
    offer_item(KIND_READ,   10'd512,  8'd0);
    offer_item(KIND_AGE,    10'd0,    8'd0);
    offer_item(KIND_READ,   10'd512,  8'd0);
    offer_item(KIND_READ,   10'd1023, 8'd0);
    offer_item(KIND_UPDATE, 10'd64,   8'd128);
    offer_item(KIND_CLEAR,  10'd1023, 8'd255);
    offer_item(KIND_READ,   10'd1023, 8'd0);
    offer_item(KIND_UPDATE, 10'd1,    8'd1);
    offer_item(KIND_READ,   10'd2,    8'd0);
    wait_drained();
    // zero limit: any positive named entry halves the table
    write_limit('0);
    offer_item(KIND_UPDATE, 10'd0,    8'd1);
    offer_item(KIND_UPDATE, 10'd5,    8'd2);
    offer_item(KIND_UPDATE, 10'd5,    8'd3);
    offer_item(KIND_READ,   10'd6,    8'd0);
    offer_item(KIND_AGE,    10'd0,    8'd0);
    offer_item(KIND_READ,   10'd5,    8'd0);
    wait_drained();
    write_limit(LIMIT_MAX);
    offer_item(KIND_UPDATE, 10'd1023, 8'd255);
    offer_item(KIND_READ,   10'd1023, 8'd0);
    offer_item(KIND_READ,   10'd0,    8'd0);

    run_phase(LIMIT_RESET, 47, 1'b0);
    run_phase('0, 47, 1'b0);
    run_phase(LIMIT_W'($urandom_range(1000, 300000)), 47, 1'b1);
    run_phase(LIMIT_MAX, 47, 1'b0);
    run_phase(LIMIT_W'($urandom), 46, 1'b0);
    run_phase(LIMIT_W'($urandom_range(0, 5000)), 46, 1'b0);

    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
